// ----- design/sfd_pkg.sv -----
// Shared types and constants for the serial frame deframer.
// No dependencies; imported by serial_frame_deframer.
package sfd_pkg;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_ADDR    = 3'd1,
		PH_LEN     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CHECK   = 3'd4,
		PH_TAIL    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD      = 2'd0,
		ST_SUM_BAD   = 2'd1,
		ST_TAIL_MISS = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_HEADER  = 2'd0,
		REG_TAIL    = 2'd1,
		REG_MAX_LEN = 2'd2
	} reg_index_t;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [7:0] HEADER_RESET  = 8'h4A;
	localparam logic [7:0] TAIL_RESET    = 8'h3B;
	localparam logic [7:0] MAX_LEN_RESET = 8'd120;

	localparam logic [7:0] POS_ADDR          = 8'd1;
	localparam logic [7:0] POS_LEN           = 8'd2;
	localparam logic [7:0] FIRST_PAYLOAD_POS = 8'd3;

endpackage

// ----- design/serial_frame_deframer.sv -----
// Serial frame deframer: header/address/length/payload/checksum/tail parser.
// Depends on sfd_pkg (phase, status and register index codes).
// The result for an accepted byte is registered in the output register and is valid in the following cycle.
// Throughput: one byte per cycle; the only limit is the single output register,
// which frees itself in the same cycle its result is taken.
// Reset (arst_n low): parser hunts for header, config registers return to
// header 0x4A, tail 0x3B, max length 120; no result pending.
module serial_frame_deframer
	import sfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	// byte input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       item_kind,
	output logic [7:0] frame_byte,
	output logic [7:0] byte_position,
	output logic [1:0] frame_status
);

	// configuration registers
	logic [7:0] header_value_q, tail_value_q, max_length_q;

	// parser state
	phase_t     phase_q, phase_d;
	logic [7:0] frame_length_q, frame_length_d;
	logic [7:0] payload_count_q, payload_count_d;
	logic [7:0] running_sum_q, running_sum_d;
	logic       sum_matched_q, sum_matched_d;

	// result register
	logic       out_valid_q;
	logic       kind_q;
	logic [7:0] byte_q, pos_q;
	logic [1:0] status_q;

	// result computed for the byte being accepted
	logic       res_valid;
	logic       res_kind;
	logic [7:0] res_byte, res_pos;
	logic [1:0] res_status;

	logic in_acc;
	logic [7:0] count_inc;

	// Accept a byte whenever the output register is empty or being drained.
	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign count_inc = payload_count_q + 8'd1;

	// Configuration writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_value_q <= HEADER_RESET;
			tail_value_q   <= TAIL_RESET;
			max_length_q   <= MAX_LEN_RESET;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_HEADER:  header_value_q <= cfg_data;
				REG_TAIL:    tail_value_q   <= cfg_data;
				REG_MAX_LEN: max_length_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next-state logic for the parser.
	always_comb begin
		phase_d         = phase_q;
		frame_length_d  = frame_length_q;
		payload_count_d = payload_count_q;
		running_sum_d   = running_sum_q;
		sum_matched_d   = sum_matched_q;
		case (phase_q)
			PH_HUNT: begin
				if (data_byte == header_value_q) begin
					phase_d         = PH_ADDR;
					frame_length_d  = '0;
					payload_count_d = '0;
					running_sum_d   = '0;
					sum_matched_d   = 1'b0;
				end
			end
			PH_ADDR: phase_d = PH_LEN;
			PH_LEN: begin
				if (data_byte > max_length_q) begin
					// oversize frame: drop silently and hunt again
					phase_d = PH_HUNT;
				end else begin
					frame_length_d  = data_byte;
					payload_count_d = '0;
					running_sum_d   = '0;
					phase_d         = (data_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				running_sum_d   = running_sum_q + data_byte;
				payload_count_d = count_inc;
				if (count_inc >= frame_length_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				sum_matched_d = (data_byte == running_sum_q);
				phase_d       = PH_TAIL;
			end
			PH_TAIL: phase_d = PH_HUNT;
			default: phase_d = PH_HUNT;
		endcase
	end

	// Result logic for the byte at the input.
	always_comb begin
		res_valid  = 1'b0;
		res_kind   = KIND_BYTE;
		res_byte   = data_byte;
		res_pos    = '0;
		res_status = ST_GOOD;
		case (phase_q)
			PH_HUNT: res_valid = 1'b0;
			PH_ADDR: begin
				res_valid = 1'b1;
				res_pos   = POS_ADDR;
			end
			PH_LEN: begin
				res_valid = (data_byte <= max_length_q);
				res_pos   = POS_LEN;
			end
			PH_PAYLOAD: begin
				res_valid = 1'b1;
				res_pos   = FIRST_PAYLOAD_POS + payload_count_q;
			end
			PH_CHECK: begin
				res_valid = 1'b1;
				res_pos   = FIRST_PAYLOAD_POS + frame_length_q;
			end
			PH_TAIL: begin
				// tail check outranks the checksum check
				res_valid = 1'b1;
				res_kind  = KIND_STATUS;
				res_byte  = '0;
				if (data_byte != tail_value_q) begin
					res_status = ST_TAIL_MISS;
				end else if (!sum_matched_q) begin
					res_status = ST_SUM_BAD;
				end else begin
					res_status = ST_GOOD;
				end
			end
			default: res_valid = 1'b0;
		endcase
	end

	// Parser state advances only on an input transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HUNT;
			frame_length_q  <= '0;
			payload_count_q <= '0;
			running_sum_q   <= '0;
			sum_matched_q   <= 1'b0;
		end else if (in_acc) begin
			phase_q         <= phase_d;
			frame_length_q  <= frame_length_d;
			payload_count_q <= payload_count_d;
			running_sum_q   <= running_sum_d;
			sum_matched_q   <= sum_matched_d;
		end
	end

	// Output register: load on an accepted byte, clear when drained, else hold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && res_valid) begin
			kind_q   <= res_kind;
			byte_q   <= res_byte;
			pos_q    <= res_pos;
			status_q <= res_status;
		end
	end

	assign out_valid     = out_valid_q;
	assign item_kind     = kind_q;
	assign frame_byte    = byte_q;
	assign byte_position = pos_q;
	assign frame_status  = status_q;

	// A tail byte always yields a status result on the next cycle.
	a_tail_status: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q == PH_TAIL) |=> (out_valid_q && kind_q == KIND_STATUS))
		else $error("tail byte did not produce a status");

	// A byte taken while hunting never produces a result.
	a_hunt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q == PH_HUNT) |=> !out_valid_q)
		else $error("result produced while hunting");

	// Payload count never passes the frame length during payload.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (payload_count_q < frame_length_q))
		else $error("payload count overran frame length");

	// Frame bytes carry a good status field.
	a_byte_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_BYTE) |-> (status_q == ST_GOOD))
		else $error("frame byte carries a nonzero status");

endmodule

// ----- tb/deframer_tb_pkg.sv -----
`timescale 1ns / 100ps
// Frame tracker for the serial frame deframer testbench: parses each byte
// and holds the frame bytes and statuses still due. Depends on sfd_pkg.
package deframer_tb_pkg;
	import sfd_pkg::*;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic [7:0] position;
		status_t    status;
	} frame_item_t;

	class deframer_tracker;
		logic [7:0]  header_value;
		logic [7:0]  tail_value;
		logic [7:0]  max_length;
		phase_t      phase;
		logic [7:0]  frame_len;
		logic [7:0]  payload_seen;
		logic [7:0]  payload_sum;
		logic        sum_ok;
		frame_item_t items_due[$];
		int unsigned bytes_taken;
		int unsigned results_predicted;
		int unsigned results_seen;
		int unsigned mismatches;
		int unsigned good_frames;
		int unsigned sum_errors;
		int unsigned tail_errors;
		int unsigned oversize_drops;

		function new();
			header_value = HEADER_RESET;
			tail_value = TAIL_RESET;
			max_length = MAX_LEN_RESET;
			phase = PH_HUNT;
			frame_len = '0;
			payload_seen = '0;
			payload_sum = '0;
			sum_ok = 1'b0;
		endfunction

		// Unknown indexes leave every register alone.
		function void write_register(logic [1:0] index, logic [7:0] data);
			case (index)
				REG_HEADER: header_value = data;
				REG_TAIL: tail_value = data;
				REG_MAX_LEN: max_length = data;
				default: ;
			endcase
		endfunction

		// Advance the parser by one accepted byte and queue what it yields.
		function void note_byte(logic [7:0] value);
			frame_item_t item;
			logic        emit;
			item.kind = KIND_BYTE;
			item.value = value;
			item.position = '0;
			item.status = ST_GOOD;
			emit = 1'b1;
			bytes_taken++;
			case (phase)
				PH_ADDR: begin
					phase = PH_LEN;
					item.position = POS_ADDR;
				end
				PH_LEN: begin
					if (value > max_length) begin
						phase = PH_HUNT;
						emit = 1'b0;
						oversize_drops++;
					end else begin
						frame_len = value;
						payload_seen = '0;
						payload_sum = '0;
						item.position = POS_LEN;
						phase = (value == 8'd0) ? PH_CHECK : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					item.position = FIRST_PAYLOAD_POS + payload_seen;
					payload_sum = payload_sum + value;
					payload_seen = payload_seen + 8'd1;
					if (payload_seen >= frame_len)
						phase = PH_CHECK;
				end
				PH_CHECK: begin
					sum_ok = (value == payload_sum);
					phase = PH_TAIL;
					item.position = FIRST_PAYLOAD_POS + frame_len;
				end
				PH_TAIL: begin
					item.kind = KIND_STATUS;
					item.value = '0;
					// a wrong tail outranks a checksum error
					if (value != tail_value) begin
						item.status = ST_TAIL_MISS;
						tail_errors++;
					end else if (!sum_ok) begin
						item.status = ST_SUM_BAD;
						sum_errors++;
					end else begin
						good_frames++;
					end
					phase = PH_HUNT;
				end
				default: begin
					emit = 1'b0;
					if (value == header_value) begin
						phase = PH_ADDR;
						frame_len = '0;
						payload_seen = '0;
						payload_sum = '0;
						sum_ok = 1'b0;
					end else begin
						phase = PH_HUNT;
					end
				end
			endcase
			if (emit) begin
				items_due.push_back(item);
				results_predicted++;
			end
		endfunction

		function void check_result(logic kind, logic [7:0] value, logic [7:0] position,
				logic [1:0] status);
			frame_item_t want;
			results_seen++;
			if (items_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing due: kind %0d byte %02h pos %0d status %0d",
						$time, kind, value, position, status);
				return;
			end
			want = items_due.pop_front();
			if (kind !== want.kind || value !== want.value || position !== want.position
					|| status !== want.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: want kind %0d byte %02h pos %0d status %0d, got kind %0d byte %02h pos %0d status %0d",
						$time, want.kind, want.value, want.position, want.status,
						kind, value, position, status);
			end
		endfunction

		function int unsigned pending();
			return items_due.size();
		endfunction
	endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level testbench for serial_frame_deframer: drives byte and register
// transactions, checks every result. Depends on sfd_pkg and deframer_tb_pkg.
module tb_top;
	import sfd_pkg::*;
	import deframer_tb_pkg::*;

	// index 3 has no register behind it
	localparam logic [1:0] UNUSED_REG_INDEX = 2'd3;

	typedef enum int {
		PACE_STEADY,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH
	} pace_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       item_kind;
	logic [7:0] frame_byte;
	logic [7:0] byte_position;
	logic [1:0] frame_status;

	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;

	deframer_tracker tracker;

	serial_frame_deframer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.item_kind    (item_kind),
		.frame_byte   (frame_byte),
		.byte_position(byte_position),
		.frame_status (frame_status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Result side: check the transaction seen at this edge, then pick the
	// ready level for the next cycle. All reads see pre-edge values.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(item_kind, frame_byte, byte_position, frame_status);
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_SENDER_IDLE: begin
				sender_idle_pct = 86;
				receiver_stall_pct = 0;
			end
			PACE_RECEIVER_STALL: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 86;
			end
			PACE_BOTH: begin
				sender_idle_pct = 29;
				receiver_stall_pct = 29;
			end
			default: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
		endcase
	endtask

	// Offer one byte. Valid stays high after the transaction so a back-to-back
	// byte never lowers and raises it in the same step; callers that pause
	// drop it themselves.
	task automatic send_byte(input logic [7:0] value);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.note_byte(value);
	endtask

	// Hold the byte channel until every frame byte and status has come out,
	// then let the last byte that gives no result settle.
	task automatic drain;
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Keep valid high across back-to-back writes; drop it once at the end.
	task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.write_register(index, data);
	endtask

	task automatic apply_settings(input logic [7:0] header, input logic [7:0] tail,
			input logic [7:0] max_len, input bit poke_unused);
		write_reg(REG_HEADER, header);
		write_reg(REG_TAIL, tail);
		write_reg(REG_MAX_LEN, max_len);
		// a write to the empty index must change nothing
		if (poke_unused)
			write_reg(UNUSED_REG_INDEX, ~header);
		cfg_valid <= 1'b0;
	endtask

	// Whole frame with random address and payload; optionally corrupt the
	// checksum and/or the tail.
	task automatic send_frame(input int len, input bit bad_sum, input bit bad_tail);
		logic [7:0] sum;
		logic [7:0] value;
		logic [7:0] tail;
		sum = '0;
		tail = tracker.tail_value;
		send_byte(tracker.header_value);
		send_byte(8'($urandom_range(0, 255)));
		send_byte(8'(len));
		for (int i = 0; i < len; i++) begin
			value = 8'($urandom_range(0, 255));
			sum = sum + value;
			send_byte(value);
		end
		send_byte(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
		send_byte(bad_tail ? tail ^ 8'($urandom_range(1, 255)) : tail);
	endtask

	// Mostly short payloads; now and then the largest one, if that stays short.
	function automatic int pick_length();
		int top;
		top = int'(tracker.max_length);
		if (top <= 40 && $urandom_range(0, 9) == 0)
			return top;
		return $urandom_range(0, (top < 12) ? top : 12);
	endfunction

	task automatic run_random(input int unsigned count);
		int unsigned goal;
		int          pick;
		int          len;
		int          top;
		goal = tracker.results_predicted + count;
		while (tracker.results_predicted < goal) begin
			pick = $urandom_range(0, 99);
			top = int'(tracker.max_length);
			if (pick < 70 || (pick >= 80 && pick < 88 && top == 255)) begin
				// well-formed frame, with the occasional bad checksum or tail
				send_frame(pick_length(), $urandom_range(0, 9) == 0,
					$urandom_range(0, 9) == 0);
			end else if (pick < 80) begin
				// line noise
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 88) begin
				// oversize length: frame must be dropped at the length byte
				send_byte(tracker.header_value);
				send_byte(8'($urandom_range(0, 255)));
				send_byte(8'($urandom_range(top + 1, 255)));
			end else if (pick < 96) begin
				// cut-off frame; following bytes land inside it
				len = pick_length();
				send_byte(tracker.header_value);
				send_byte(8'($urandom_range(0, 255)));
				send_byte(8'(len));
				repeat ($urandom_range(0, len))
					send_byte(8'($urandom_range(0, 255)));
			end else begin
				// header straight into another header: second one is the address
				send_byte(tracker.header_value);
				send_frame(pick_length(), 1'b0, 1'b0);
			end
			// pause now and then until the output side has caught up
			if ($urandom_range(0, 199) == 0)
				drain();
		end
	endtask

	// Frames of every shape at the reset settings.
	task automatic run_opening;
		logic [7:0] opening[$];
		opening = '{
			8'h00,
			HEADER_RESET, 8'h00, 8'h00, 8'h00, TAIL_RESET,
			HEADER_RESET, 8'hFF, 8'h01, 8'hFF, 8'h00, TAIL_RESET,
			HEADER_RESET, 8'h12, MAX_LEN_RESET + 8'd1,
			HEADER_RESET, 8'h55, 8'h01, 8'h80, 8'h80, TAIL_RESET ^ 8'hFF,
			HEADER_RESET, 8'hAA, 8'h00, 8'h01, 8'h00
		};
		foreach (opening[i])
			send_byte(opening[i]);
	endtask

	initial begin
		tracker = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		set_pace(PACE_STEADY);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_opening();
		run_random(180);
		drain();

		// zero header, all-ones tail, no payload allowed
		apply_settings(8'h00, 8'hFF, 8'd0, 1'b0);
		set_pace(PACE_SENDER_IDLE);
		run_random(160);
		drain();

		// widest settings; one full-length frame wraps the position counter
		apply_settings(8'hFF, 8'h00, 8'd255, 1'b1);
		set_pace(PACE_RECEIVER_STALL);
		send_frame(255, 1'b0, 1'b0);
		run_random(50);
		drain();

		apply_settings(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)),
			8'($urandom_range(3, 40)), 1'b1);
		set_pace(PACE_BOTH);
		run_random(280);
		drain();

		apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(1, 20)), 1'b0);
		set_pace(PACE_STEADY);
		run_random(120);
		set_pace(PACE_BOTH);
		run_random(120);
		drain();
		repeat (8) @(posedge clk);

		$display("Covered %0d bytes and %0d results over five register settings.",
			tracker.bytes_taken, tracker.results_seen);
		$display("Frames: %0d good, %0d checksum errors, %0d missing tails, %0d oversize drops.",
			tracker.good_frames, tracker.sum_errors, tracker.tail_errors,
			tracker.oversize_drops);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
design/sfd_pkg.sv
design/serial_frame_deframer.sv
tb/deframer_tb_pkg.sv
tb/tb_top.sv
